FILE: hdl/hcd_pkg.sv
// shared types, constants and helpers for the hex chunk deframer
package hcd_pkg;

    // chunk framing phase
    typedef enum logic [1:0] {
        PH_LEN_HI = 2'd0,
        PH_LEN_LO = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    // status codes of the final record
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_HEX   = 3'd1;
    localparam logic [2:0] ST_ODD_DIGIT = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_BAD_FIRST = 3'd4;
    localparam logic [2:0] ST_TINY_LEN  = 3'd5;

    localparam logic [23:0] BYTE_SAT   = 24'hFF_FFFF;
    localparam logic [15:0] CHUNK_SAT  = 16'hFFFF;
    localparam logic [15:0] MIN_LEN    = 16'd5;
    localparam logic [23:0] MIN_BYTES  = 24'd5;

    // character codes
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_UA  = 8'h41;
    localparam logic [7:0] CH_UF  = 8'h46;
    localparam logic [7:0] CH_LA  = 8'h61;
    localparam logic [7:0] CH_LF_ = 8'h66;

    // results caused by one input item
    typedef struct packed {
        logic        pay_valid;
        logic [7:0]  pay_byte;
        logic        pay_end;
        logic        flush_valid;
        logic [7:0]  flush_byte0;
        logic [7:0]  flush_byte1;
        logic        status_valid;
        logic [2:0]  status;
        logic [15:0] frame_count;
        logic [15:0] first_size;
        logic [23:0] decoded;
    } step_res_t;

    // hex digit decode: bit 4 set when the character is a digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
            return {1'b1, d[3:0]};
        end else if (c >= CH_LA && c <= CH_LF_) begin
            d = c - CH_LA + 8'd10;
            return {1'b1, d[3:0]};
        end else if (c >= CH_UA && c <= CH_UF) begin
            d = c - CH_UA + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

FILE: hdl/hcd_core.sv
// decode and chunk state of the hex chunk deframer, one character per cycle while in_fire is high
module hcd_core
    import hcd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] ascii_char,
    input  logic       last,
    output step_res_t  res
);

    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic        have_high_reg, have_high_next;
    logic        line_done_reg, line_done_next;
    logic [2:0]  error_code_reg, error_code_next;
    logic [23:0] byte_count_reg, byte_count_next;
    logic [15:0] first_length_reg, first_length_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [15:0] chunk_length_reg, chunk_length_next;
    logic [15:0] body_index_reg, body_index_next;
    logic [7:0]  held0_reg, held0_next;
    logic [7:0]  held1_reg, held1_next;
    logic [1:0]  held_count_reg, held_count_next;
    logic [15:0] chunks_reg, chunks_next;
    phase_t      phase_reg, phase_next;

    logic [4:0]  dig;
    logic [7:0]  new_byte;
    logic        chunk_fin;
    logic        do_flush;
    logic [2:0]  st;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_nibble_reg  <= '0;
            have_high_reg    <= 1'b0;
            line_done_reg    <= 1'b0;
            error_code_reg   <= ST_OK;
            byte_count_reg   <= '0;
            first_length_reg <= '0;
            length_high_reg  <= '0;
            chunk_length_reg <= '0;
            body_index_reg   <= '0;
            held_count_reg   <= '0;
            chunks_reg       <= '0;
            phase_reg        <= PH_LEN_HI;
        end else if (in_fire) begin
            high_nibble_reg  <= high_nibble_next;
            have_high_reg    <= have_high_next;
            line_done_reg    <= line_done_next;
            error_code_reg   <= error_code_next;
            byte_count_reg   <= byte_count_next;
            first_length_reg <= first_length_next;
            length_high_reg  <= length_high_next;
            chunk_length_reg <= chunk_length_next;
            body_index_reg   <= body_index_next;
            held_count_reg   <= held_count_next;
            chunks_reg       <= chunks_next;
            phase_reg        <= phase_next;
        end
    end

    // held payload bytes, no reset needed
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

    // character decode, chunk framing and final status
    always_comb begin
        high_nibble_next  = high_nibble_reg;
        have_high_next    = have_high_reg;
        line_done_next    = line_done_reg;
        error_code_next   = error_code_reg;
        byte_count_next   = byte_count_reg;
        first_length_next = first_length_reg;
        length_high_next  = length_high_reg;
        chunk_length_next = chunk_length_reg;
        body_index_next   = body_index_reg;
        held0_next        = held0_reg;
        held1_next        = held1_reg;
        held_count_next   = held_count_reg;
        chunks_next       = chunks_reg;
        phase_next        = phase_reg;
        res               = '0;
        dig               = hex_digit(ascii_char);
        new_byte          = {high_nibble_reg, dig[3:0]};
        chunk_fin         = (body_index_reg + 16'd1) == chunk_length_reg;
        do_flush          = 1'b0;
        st                = ST_OK;

        if (!line_done_reg && error_code_reg != ST_BAD_HEX) begin
            if (ascii_char == CH_NUL || ascii_char == CH_LF || ascii_char == CH_CR) begin
                line_done_next = 1'b1;
            end else if (ascii_char == CH_SP || ascii_char == CH_TAB ||
                         ascii_char == CH_VT || ascii_char == CH_FF) begin
                // whitespace skipped
            end else if (!dig[4]) begin
                error_code_next = ST_BAD_HEX;
            end else if (!have_high_reg) begin
                high_nibble_next = dig[3:0];
                have_high_next   = 1'b1;
            end else begin
                have_high_next = 1'b0;
                if (byte_count_reg != BYTE_SAT) begin
                    byte_count_next = byte_count_reg + 24'd1;
                end
                if (error_code_reg == ST_OK) begin
                    case (phase_reg)
                        PH_LEN_HI: begin
                            length_high_next = new_byte;
                            phase_next       = PH_LEN_LO;
                        end
                        PH_LEN_LO: begin
                            chunk_length_next = {length_high_reg, new_byte};
                            if (byte_count_next == 24'd2) begin
                                first_length_next = {length_high_reg, new_byte};
                            end
                            phase_next      = PH_BODY;
                            body_index_next = '0;
                            held_count_next = '0;
                        end
                        PH_BODY: begin
                            if (body_index_reg == 16'd0 && chunk_length_reg < MIN_LEN) begin
                                error_code_next = ST_TINY_LEN;
                            end else begin
                                // payload goes out two bytes late
                                if (held_count_reg >= 2'd2) begin
                                    res.pay_valid = 1'b1;
                                    res.pay_byte  = held0_reg;
                                    res.pay_end   = chunk_fin;
                                end
                                held0_next = held1_reg;
                                held1_next = new_byte;
                                if (held_count_reg < 2'd2) begin
                                    held_count_next = held_count_reg + 2'd1;
                                end
                                if (chunk_fin) begin
                                    if (chunks_reg != CHUNK_SAT) begin
                                        chunks_next = chunks_reg + 16'd1;
                                    end
                                    phase_next      = PH_LEN_HI;
                                    held_count_next = '0;
                                    body_index_next = '0;
                                end else begin
                                    body_index_next = body_index_reg + 16'd1;
                                end
                            end
                        end
                        default: begin
                            phase_next = PH_LEN_HI;
                        end
                    endcase
                end
            end
        end

        // end of file: status record, optional tail flush, back to reset state
        if (last) begin
            if (error_code_next == ST_BAD_HEX) begin
                st = ST_BAD_HEX;
            end else if (have_high_next) begin
                st = ST_ODD_DIGIT;
            end else if (byte_count_next < MIN_BYTES) begin
                st = ST_SHORT;
            end else if (first_length_next < MIN_LEN ||
                         {8'd0, first_length_next} > byte_count_next) begin
                st = ST_BAD_FIRST;
            end else begin
                st = error_code_next;
            end
            do_flush = (st == ST_OK) && (phase_next == PH_BODY) &&
                       (body_index_next >= 16'd3);
            res.flush_valid  = do_flush;
            res.flush_byte0  = held0_next;
            res.flush_byte1  = held1_next;
            res.status_valid = 1'b1;
            res.status       = st;
            res.first_size   = first_length_next;
            res.decoded      = byte_count_next;
            if (do_flush && chunks_next != CHUNK_SAT) begin
                res.frame_count = chunks_next + 16'd1;
            end else begin
                res.frame_count = chunks_next;
            end
            high_nibble_next  = '0;
            have_high_next    = 1'b0;
            line_done_next    = 1'b0;
            error_code_next   = ST_OK;
            byte_count_next   = '0;
            first_length_next = '0;
            length_high_next  = '0;
            chunk_length_next = '0;
            body_index_next   = '0;
            held_count_next   = '0;
            chunks_next       = '0;
            phase_next        = PH_LEN_HI;
        end
    end

endmodule

FILE: hdl/hex_chunk_deframer_unit.sv
// top level of the hex chunk deframer: input handshake and result register
//
// Usage: the s_ channel takes one ASCII character of a firmware image per
// item, with s_last on the final character of the file. Hex digit pairs
// become bytes; chunks of [length][payload][crc] are unpacked and the
// payload bytes leave on the m_ channel (m_kind 0, m_frame_end on the last
// byte of a chunk). After the last character a status record follows
// (m_kind 1) with status, chunk count, first chunk size and byte count.
// Latency: a result caused by an item is offered the cycle after the item
// is accepted. Throughput: one item per cycle while each item causes at
// most one result; the final item causes up to four results (payload byte,
// two tail bytes, status) and these leave one per cycle from the result
// register, which holds input back until the last of them has left.
// A new item is taken in the same cycle that the last waiting result
// leaves. When the receiver stalls, the result holds and s_ready drops.
// Reset (aresetn low, synchronous) clears all decode state and drops any
// waiting result; the block then expects the start of a new file.
module hex_chunk_deframer_unit
    import hcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ascii_char,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_data_byte,
    output logic        m_frame_end,
    output logic [2:0]  m_status,
    output logic [15:0] m_frame_count,
    output logic [15:0] m_first_chunk_size,
    output logic [23:0] m_decoded_bytes
);

    step_res_t  step;
    step_res_t  res_reg;
    // waiting results: bit 0 payload, 1 tail byte 0, 2 tail byte 1, 3 status
    logic [3:0] pend_reg, pend_next;
    logic [3:0] lowest;
    logic [3:0] pend_left;
    logic       in_fire;

    assign in_fire = s_valid && s_ready;

    hcd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .ascii_char (s_ascii_char),
        .last       (s_last),
        .res        (step)
    );

    // result leaving this cycle is the lowest waiting one
    always_comb begin
        lowest    = pend_reg & (~pend_reg + 4'd1);
        pend_left = m_ready ? (pend_reg & ~lowest) : pend_reg;
        s_ready   = (pend_left == 4'd0);
        if (in_fire) begin
            pend_next = {step.status_valid, step.flush_valid,
                         step.flush_valid, step.pay_valid};
        end else begin
            pend_next = pend_left;
        end
    end

    // pending flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // result payload register
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            res_reg <= step;
        end
    end

    // output selection
    always_comb begin
        m_valid            = (pend_reg != 4'd0);
        m_kind             = 1'b0;
        m_data_byte        = '0;
        m_frame_end        = 1'b0;
        m_status           = ST_OK;
        m_frame_count      = '0;
        m_first_chunk_size = '0;
        m_decoded_bytes    = '0;
        if (pend_reg[0]) begin
            m_data_byte = res_reg.pay_byte;
            m_frame_end = res_reg.pay_end;
        end else if (pend_reg[1]) begin
            m_data_byte = res_reg.flush_byte0;
        end else if (pend_reg[2]) begin
            m_data_byte = res_reg.flush_byte1;
            m_frame_end = 1'b1;
        end else if (pend_reg[3]) begin
            m_kind             = 1'b1;
            m_status           = res_reg.status;
            m_frame_count      = res_reg.frame_count;
            m_first_chunk_size = res_reg.first_size;
            m_decoded_bytes    = res_reg.decoded;
        end
    end

endmodule

FILE: tb/tb_hex_chunk_deframer_unit.sv
// testbench for the hex chunk deframer: image text stimulus, result prediction and checking
`timescale 1ns / 100ps

module tb_hex_chunk_deframer_unit;
    import hcd_pkg::*;

    localparam int   CLK_HALF     = 4;
    localparam int   RANDOM_ITEMS = 480;
    localparam int   STALL_LIMIT  = 5000;
    localparam int   TAIL_CYCLES  = 8;
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // one result item as seen on the m_ channel
    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic        frame_end;
        logic [2:0]  status;
        logic [15:0] frame_count;
        logic [15:0] first_size;
        logic [23:0] decoded;
    } deframe_res_t;

    // shapes of generated image files
    typedef enum int {
        FK_CLEAN,
        FK_BAD_HEX,
        FK_ODD,
        FK_SHORT,
        FK_BAD_FIRST,
        FK_TINY,
        FK_NOISE,
        FK_COUNT
    } file_kind_t;

    // predicts the deframer output and checks each result against it
    class deframe_scoreboard;
        logic [3:0]   hi_nib;
        logic         hi_seen;
        logic         text_done;
        logic [2:0]   err;
        logic [23:0]  byte_cnt;
        logic [15:0]  first_len;
        logic [7:0]   len_hi;
        logic [15:0]  chunk_len;
        int           body_idx;
        logic [7:0]   held [2];
        int           held_cnt;
        logic [15:0]  chunk_cnt;
        phase_t       phase;
        deframe_res_t expected_q [$];
        int           fail_count;
        int           payload_seen;
        int           status_seen [6];

        function new();
            fail_count   = 0;
            payload_seen = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            clear_state();
        endfunction

        function void clear_state();
            hi_nib    = '0;
            hi_seen   = 1'b0;
            text_done = 1'b0;
            err       = ST_OK;
            byte_cnt  = '0;
            first_len = '0;
            len_hi    = '0;
            chunk_len = '0;
            body_idx  = 0;
            held[0]   = '0;
            held[1]   = '0;
            held_cnt  = 0;
            chunk_cnt = '0;
            phase     = PH_LEN_HI;
        endfunction

        static function int hex_value(logic [7:0] c);
            if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
            if (c >= CH_LA && c <= CH_LF_) return int'(c - CH_LA) + 10;
            if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
            return -1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void queue_result(logic kind, logic [7:0] data, logic fe, logic [2:0] st,
                                   logic [15:0] fc, logic [15:0] fs, logic [23:0] db);
            deframe_res_t r;
            r.kind        = kind;
            r.data_byte   = data;
            r.frame_end   = fe;
            r.status      = st;
            r.frame_count = fc;
            r.first_size  = fs;
            r.decoded     = db;
            expected_q.push_back(r);
        endfunction

        function void count_chunk();
            if (chunk_cnt < CHUNK_SAT) chunk_cnt++;
        endfunction

        // chunk framing of one decoded byte; payload leaves two bytes late
        function void take_byte(logic [7:0] b);
            logic is_end;
            case (phase)
                PH_LEN_HI: begin
                    len_hi = b;
                    phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    chunk_len = {len_hi, b};
                    if (byte_cnt == 24'd2) first_len = chunk_len;
                    phase    = PH_BODY;
                    body_idx = 0;
                    held_cnt = 0;
                end
                default: begin
                    if (body_idx == 0 && chunk_len < MIN_LEN) begin
                        err = ST_TINY_LEN;
                    end else begin
                        is_end = (body_idx + 1 == int'(chunk_len));
                        if (held_cnt >= 2)
                            queue_result(KIND_PAYLOAD, held[0], is_end, ST_OK, '0, '0, '0);
                        held[0] = held[1];
                        held[1] = b;
                        if (held_cnt < 2) held_cnt++;
                        if (is_end) begin
                            count_chunk();
                            phase    = PH_LEN_HI;
                            held_cnt = 0;
                            body_idx = 0;
                        end else begin
                            body_idx = body_idx + 1;
                        end
                    end
                end
            endcase
        endfunction

        // one accepted input item
        function void note_item(logic [7:0] c, logic lst);
            int         v;
            logic [2:0] st;
            // character decode until a terminator or a bad character
            if (!text_done && err != ST_BAD_HEX) begin
                if (c == CH_NUL || c == CH_LF || c == CH_CR) begin
                    text_done = 1'b1;
                end else if (!(c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF)) begin
                    v = hex_value(c);
                    if (v < 0) begin
                        err = ST_BAD_HEX;
                    end else if (!hi_seen) begin
                        hi_nib  = v[3:0];
                        hi_seen = 1'b1;
                    end else begin
                        hi_seen = 1'b0;
                        if (byte_cnt < BYTE_SAT) byte_cnt++;
                        if (err == ST_OK) take_byte({hi_nib, v[3:0]});
                    end
                end
            end
            // end of file: tail flush and status record
            if (lst) begin
                if (err == ST_BAD_HEX) st = ST_BAD_HEX;
                else if (hi_seen) st = ST_ODD_DIGIT;
                else if (byte_cnt < MIN_BYTES) st = ST_SHORT;
                else if (first_len < MIN_LEN || 24'(first_len) > byte_cnt) st = ST_BAD_FIRST;
                else st = err;
                if (st == ST_OK && phase == PH_BODY && body_idx >= 3) begin
                    queue_result(KIND_PAYLOAD, held[0], 1'b0, ST_OK, '0, '0, '0);
                    queue_result(KIND_PAYLOAD, held[1], 1'b1, ST_OK, '0, '0, '0);
                    count_chunk();
                end
                queue_result(KIND_STATUS, 8'd0, 1'b0, st, chunk_cnt, first_len, byte_cnt);
                clear_state();
            end
        endfunction

        function void check_field(string name, logic [23:0] want, logic [23:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                fail_count++;
            end
        endfunction

        // one accepted result item against the oldest prediction
        function void check_result(deframe_res_t got);
            deframe_res_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, %s %0d data %02h status %0d",
                         $time, "actual kind", got.kind, got.data_byte, got.status);
                fail_count++;
                return;
            end
            want = expected_q.pop_front();
            check_field("kind", 24'(want.kind), 24'(got.kind));
            check_field("data_byte", 24'(want.data_byte), 24'(got.data_byte));
            check_field("frame_end", 24'(want.frame_end), 24'(got.frame_end));
            check_field("status", 24'(want.status), 24'(got.status));
            check_field("frame_count", 24'(want.frame_count), 24'(got.frame_count));
            check_field("first_chunk_size", 24'(want.first_size), 24'(got.first_size));
            check_field("decoded_bytes", want.decoded, got.decoded);
            if (want.kind == KIND_STATUS) status_seen[want.status]++;
            else payload_seen++;
        endfunction
    endclass

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [7:0]  s_ascii_char = 8'd0;
    logic        s_last       = 1'b0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic        m_kind;
    logic [7:0]  m_data_byte;
    logic        m_frame_end;
    logic [2:0]  m_status;
    logic [15:0] m_frame_count;
    logic [15:0] m_first_chunk_size;
    logic [23:0] m_decoded_bytes;

    int                send_idle_pct = 32;
    int                recv_idle_pct = 53;
    int                items_sent    = 0;
    int                files_sent    = 0;
    int                quiet_cycles  = 0;
    int                live_len      = 0;
    logic [7:0]        file_bytes [$];
    logic [7:0]        file_text [$];
    deframe_scoreboard sb;

    hex_chunk_deframer_unit u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_ascii_char       (s_ascii_char),
        .s_last             (s_last),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_data_byte        (m_data_byte),
        .m_frame_end        (m_frame_end),
        .m_status           (m_status),
        .m_frame_count      (m_frame_count),
        .m_first_chunk_size (m_first_chunk_size),
        .m_decoded_bytes    (m_decoded_bytes)
    );

    // clock
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // receiver stalls
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // handshake monitor and watchdog
    always @(posedge aclk) begin : monitor
        deframe_res_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_kind, m_data_byte, m_frame_end, m_status, m_frame_count,
                       m_first_chunk_size, m_decoded_bytes};
                sb.check_result(got);
            end
            if (s_valid && s_ready) sb.note_item(s_ascii_char, s_last);
            if ((m_valid && m_ready) || (s_valid && s_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, sb.pending());
                $display("hex_chunk_deframer_unit test failed");
                $finish;
            end
        end
    end

    // one item, with random idle cycles ahead of it
    task automatic send_char(input logic [7:0] c, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_ascii_char <= c;
        s_last       <= lst;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_text.size(); i++)
            send_char(file_text[i], i == file_text.size() - 1);
        items_sent += live_len;
        files_sent++;
    endtask

    // hold the input back until every predicted result has arrived
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    function automatic logic [7:0] digit_char(logic [3:0] nib);
        if (nib < 4'd10) return CH_0 + nib;
        return (($urandom_range(1) == 0) ? CH_UA : CH_LA) + nib - 4'd10;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(3))
            0: return CH_SP;
            1: return CH_TAB;
            2: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function automatic bit is_plain_char(logic [7:0] c);
        return deframe_scoreboard::hex_value(c) >= 0 || c == CH_SP || c == CH_TAB ||
               c == CH_VT || c == CH_FF || c == CH_NUL || c == CH_LF || c == CH_CR;
    endfunction

    function automatic int pick_len();
        if ($urandom_range(9) == 0) return $urandom_range(40, 13);
        return $urandom_range(12, 5);
    endfunction

    function automatic void add_chunk(int len, int body_n);
        file_bytes.push_back(len[15:8]);
        file_bytes.push_back(len[7:0]);
        repeat (body_n) file_bytes.push_back(8'($urandom_range(255)));
    endfunction

    // bytes to hex text with scattered whitespace and mixed case
    function automatic void render_bytes();
        file_text.delete();
        foreach (file_bytes[i]) begin
            if ($urandom_range(9) == 0) file_text.push_back(blank_char());
            file_text.push_back(digit_char(file_bytes[i][7:4]));
            if ($urandom_range(19) == 0) file_text.push_back(blank_char());
            file_text.push_back(digit_char(file_bytes[i][3:0]));
        end
    endfunction

    // optional terminator followed by ignored characters
    function automatic void close_text();
        if ($urandom_range(9) < 4) begin
            case ($urandom_range(2))
                0: file_text.push_back(CH_NUL);
                1: file_text.push_back(CH_LF);
                default: file_text.push_back(CH_CR);
            endcase
            live_len = file_text.size();
            repeat ($urandom_range(3)) file_text.push_back(8'($urandom_range(255)));
        end else begin
            live_len = file_text.size();
        end
        if (file_text.size() == 0) begin
            file_text.push_back(blank_char());
            live_len = 1;
        end
    endfunction

    function automatic void build_file(file_kind_t kind);
        int         n_chunks;
        int         len;
        int         body_n;
        logic [7:0] bad;
        file_bytes.delete();
        file_text.delete();
        case (kind)
            FK_CLEAN, FK_BAD_HEX, FK_ODD: begin
                n_chunks = $urandom_range(3, 1);
                for (int k = 0; k < n_chunks; k++) begin
                    len    = pick_len();
                    body_n = len;
                    // truncated last chunk, sometimes with the largest length field
                    if (k == n_chunks - 1 && $urandom_range(9) < 3) begin
                        if ($urandom_range(9) == 0) len = 16'hFFFF;
                        body_n = $urandom_range((len - 1 < 11) ? len - 1 : 11);
                    end
                    add_chunk(len, body_n);
                end
                render_bytes();
                if (kind == FK_BAD_HEX) begin
                    do bad = 8'($urandom_range(255)); while (is_plain_char(bad));
                    file_text.insert($urandom_range(file_text.size() - 1), bad);
                end
                if (kind == FK_ODD) file_text.push_back(digit_char(4'($urandom_range(15))));
            end
            FK_SHORT: begin
                repeat ($urandom_range(4)) file_bytes.push_back(8'($urandom_range(255)));
                render_bytes();
            end
            FK_BAD_FIRST: begin
                body_n = $urandom_range(10, 3);
                if ($urandom_range(1) == 0) len = $urandom_range(4);
                else len = $urandom_range(16'hFFFF, body_n + 3);
                add_chunk(len, body_n);
                render_bytes();
            end
            FK_TINY: begin
                len = pick_len();
                add_chunk(len, len);
                add_chunk($urandom_range(4), $urandom_range(4));
                render_bytes();
            end
            default: begin
                repeat ($urandom_range(12, 1)) file_text.push_back(8'($urandom_range(255)));
            end
        endcase
        close_text();
    endfunction

    initial begin
        int         r;
        int         rnd_files;
        int         seg;
        file_kind_t kind;
        sb = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: "00 05<tab>Ab<vt>cD<ff>eF<cr>" then an ignored byte, truncated tail flush
        file_text = '{CH_0, CH_0, CH_SP, CH_0, 8'h35, CH_TAB, 8'h41, 8'h62, CH_VT,
                      8'h63, 8'h44, CH_FF, 8'h65, 8'h46, CH_CR, 8'hA5};
        live_len = file_text.size();
        send_file();
        // bad character with every bit set
        file_text = '{8'hFF};
        live_len = 1;
        send_file();
        // lone digit
        file_text = '{8'h39};
        live_len = 1;
        send_file();
        // two bytes ended by a nul, too short
        file_text = '{CH_0, 8'h61, CH_0, 8'h42, CH_NUL};
        live_len = file_text.size();
        send_file();
        wait_for_results();

        // random files over three idling phases
        items_sent = 0;
        rnd_files  = 0;
        while (items_sent < RANDOM_ITEMS) begin
            seg = items_sent * 3 / RANDOM_ITEMS;
            send_idle_pct = (seg == 0) ? 32 : (seg == 1) ? 53 : 0;
            recv_idle_pct = (seg == 0) ? 53 : (seg == 1) ? 32 : 0;
            if (rnd_files < FK_COUNT) begin
                kind = file_kind_t'(rnd_files);
            end else begin
                r = $urandom_range(99);
                if (r < 60) kind = FK_CLEAN;
                else if (r < 67) kind = FK_BAD_HEX;
                else if (r < 74) kind = FK_ODD;
                else if (r < 80) kind = FK_SHORT;
                else if (r < 87) kind = FK_BAD_FIRST;
                else if (r < 93) kind = FK_TINY;
                else kind = FK_NOISE;
            end
            build_file(kind);
            send_file();
            rnd_files++;
            if ($urandom_range(4) == 0) wait_for_results();
        end

        // drain and settle
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("covered %0d files (%0d random items): %0d payload bytes, %0d %s",
                 files_sent, items_sent, sb.payload_seen,
                 sb.status_seen[0] + sb.status_seen[1] + sb.status_seen[2] +
                 sb.status_seen[3] + sb.status_seen[4] + sb.status_seen[5],
                 "status records");
        $display("status mix: ok %0d, bad hex %0d, odd digits %0d, short %0d, %s %0d, tiny %0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3], "bad first", sb.status_seen[4], sb.status_seen[5]);
        if (sb.fail_count == 0) begin
            $display("hex_chunk_deframer_unit test passed");
        end else begin
            $display("hex_chunk_deframer_unit test failed");
        end
        $finish;
    end

endmodule
